// ===== design/cfr_pkg.sv =====
// Shared types, codes and helpers for the command frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    localparam int CHUNK_BYTES = 256;
    localparam int CHUNK_W     = $clog2(CHUNK_BYTES + 1);

    localparam int MAXP_W  = 9;
    localparam int LEN_W   = 16;
    localparam int OP_W    = 3;
    localparam int KIND_W  = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 9'd256;

    localparam logic [7:0] CH_START = 8'h25;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_G     = 8'h47;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BODY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

    localparam logic [OP_W-1:0] OP_DECODE    = 3'd0;
    localparam logic [OP_W-1:0] OP_SUBSCRIBE = 3'd1;
    localparam logic [OP_W-1:0] OP_LIST      = 3'd2;
    localparam logic [OP_W-1:0] OP_ACK       = 3'd3;
    localparam logic [OP_W-1:0] OP_ERROR     = 3'd4;
    localparam logic [OP_W-1:0] OP_DEBUG     = 3'd5;
    localparam logic [OP_W-1:0] OP_UNKNOWN   = 3'd6;

    // Slots of one result burst, in transfer order.
    localparam int SLOT_START = 0;
    localparam int SLOT_BODY  = 1;
    localparam int SLOT_ACK0  = 2;
    localparam int SLOT_END   = 6;
    localparam int SLOTS      = 7;
    localparam int SLOT_W     = 3;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_OP     = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_LEN_HI = 5'b01000,
        PH_BODY   = 5'b10000
    } phase_t;

    function automatic logic [OP_W-1:0] op_of_letter(input logic [7:0] c);
        logic [OP_W-1:0] op;
        case (c)
            CH_D:    op = OP_DECODE;
            CH_S:    op = OP_SUBSCRIBE;
            CH_L:    op = OP_LIST;
            CH_A:    op = OP_ACK;
            CH_E:    op = OP_ERROR;
            CH_G:    op = OP_DEBUG;
            default: op = OP_UNKNOWN;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] ack_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = CH_START;
            2'd1:    v = CH_A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/command_frame_receiver.sv =====
// Command frame receiver top level: header decode, body pass/discard, ack bursts.
//
// Accepts one received byte per transfer on s_ and returns result items on m_.
// A byte is decoded in the cycle it is accepted and its results (zero to six
// items) are loaded into one output burst register, which sends one item per
// cycle while m_tready is high, in the order start, body byte, four ack bytes,
// end; m_tlast marks the final item of a byte. The next byte is accepted in
// the cycle the last item of the burst transfers, or at once with no burst
// pending, so the burst register holds off the input until its burst is done.
// m_tuser holds the item kind; cfg_we writes max_payload, which takes effect
// at the next header.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_receiver
    import cfr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [MAXP_W-1:0]    cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // [7:0] byte_value, [10:8] op_kind,
                                                 // [26:11] length, [27] dropped
    output logic [KIND_W-1:0]         m_tuser,   // [1:0] kind
    output logic                      m_tlast
);

    phase_t               phase_reg, phase_next;
    logic [MAXP_W-1:0]    max_payload_reg;
    logic [OP_W-1:0]      held_op_reg, held_op_next;
    logic [LEN_W-1:0]     held_len_reg, held_len_next;
    logic [LEN_W-1:0]     seen_reg, seen_next;
    logic [CHUNK_W-1:0]   fill_reg, fill_next;
    logic                 disc_reg, disc_next;

    logic [SLOTS-1:0]     mask_reg, mask_next, load_mask;
    logic [7:0]           out_byte_reg;
    logic [OP_W-1:0]      out_op_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic                 out_drop_reg;

    logic                 s_xfer, m_xfer;
    logic [SLOTS-1:0]     low_bit;
    logic [SLOT_W-1:0]    slot;
    logic [1:0]           ack_idx;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    always_comb begin
        logic [LEN_W-1:0]   len_v;
        logic [LEN_W-1:0]   seen_inc;
        logic [CHUNK_W-1:0] fill_inc;
        logic               done;
        phase_next    = phase_reg;
        held_op_next  = held_op_reg;
        held_len_next = held_len_reg;
        seen_next     = seen_reg;
        fill_next     = fill_reg;
        disc_next     = disc_reg;
        load_mask     = '0;
        len_v         = {s_tdata, held_len_reg[7:0]};
        seen_inc      = seen_reg + LEN_W'(1);
        fill_inc      = fill_reg + CHUNK_W'(1);
        done          = (seen_inc == held_len_reg);
        case (phase_reg)
            PH_HUNT: begin
                if (s_tdata == CH_START) begin
                    phase_next = PH_OP;
                end
            end
            PH_OP: begin
                held_op_next = op_of_letter(s_tdata);
                phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                held_len_next = {8'h00, s_tdata};
                phase_next    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                held_len_next = len_v;
                seen_next     = '0;
                fill_next     = '0;
                disc_next     = (len_v > {{(LEN_W-MAXP_W){1'b0}}, max_payload_reg});
                load_mask[SLOT_START] = 1'b1;
                load_mask[SLOT_ACK0 +: 4] = 4'hF;
                if (len_v == '0) begin
                    load_mask[SLOT_END] = 1'b1;
                    phase_next = PH_HUNT;
                end else begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                seen_next = seen_inc;
                if (disc_reg) begin
                    if (fill_inc >= CHUNK_W'(CHUNK_BYTES) || done) begin
                        load_mask[SLOT_ACK0 +: 4] = 4'hF;
                        fill_next = '0;
                    end else begin
                        fill_next = fill_inc;
                    end
                end else begin
                    load_mask[SLOT_BODY] = 1'b1;
                    if (done) begin
                        load_mask[SLOT_ACK0 +: 4] = 4'hF;
                    end
                end
                if (done) begin
                    load_mask[SLOT_END] = 1'b1;
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Lowest pending slot is the item on the output.
    assign low_bit = mask_reg & (~mask_reg + SLOTS'(1));

    always_comb begin
        slot = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (low_bit[i]) begin
                slot = SLOT_W'(i);
            end
        end
    end

    assign ack_idx = 2'(slot - SLOT_W'(SLOT_ACK0));

    always_comb begin
        mask_next = mask_reg;
        if (m_xfer) begin
            mask_next = mask_reg & ~low_bit;
        end
        if (s_xfer) begin
            mask_next = load_mask;
        end
    end

    assign m_tvalid = |mask_reg;
    assign m_tlast  = (mask_reg == low_bit);
    assign s_tready = !m_tvalid || (m_tready && m_tlast);

    always_comb begin
        logic [7:0] byte_v;
        if (slot == SLOT_W'(SLOT_START)) begin
            m_tuser = KIND_START;
            byte_v  = 8'h00;
        end else if (slot == SLOT_W'(SLOT_BODY)) begin
            m_tuser = KIND_BODY;
            byte_v  = out_byte_reg;
        end else if (slot == SLOT_W'(SLOT_END)) begin
            m_tuser = KIND_END;
            byte_v  = 8'h00;
        end else begin
            m_tuser = KIND_ACK;
            byte_v  = ack_byte(ack_idx);
        end
        m_tdata = {4'h0, out_drop_reg, out_len_reg, out_op_reg, byte_v};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            max_payload_reg <= MAX_PAYLOAD_RST;
            held_op_reg     <= '0;
            held_len_reg    <= '0;
            seen_reg        <= '0;
            fill_reg        <= '0;
            disc_reg        <= 1'b0;
            mask_reg        <= '0;
        end else begin
            if (cfg_we) begin
                max_payload_reg <= cfg_wdata;
            end
            if (s_xfer) begin
                phase_reg    <= phase_next;
                held_op_reg  <= held_op_next;
                held_len_reg <= held_len_next;
                seen_reg     <= seen_next;
                fill_reg     <= fill_next;
                disc_reg     <= disc_next;
            end
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_byte_reg <= s_tdata;
            out_op_reg   <= held_op_next;
            out_len_reg  <= held_len_next;
            out_drop_reg <= disc_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/cfr_checker.sv =====
// Port-level checker for the command frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cfr_checker
    import cfr_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]   m_tuser,
    input wire logic                m_tlast
);

    // Hold a stalled result.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled result changed");

    // Take no new byte while a burst still has items to transfer.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !(m_tready && m_tlast)) |-> !s_tready)
        else $error("input taken while burst pending");

    // A command start never ends a burst.
    a_start_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_START) |-> !m_tlast)
        else $error("command start ended a burst");

    // Ack items carry only ack frame bytes.
    a_ack_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ACK) |->
            (m_tdata[7:0] == CH_START || m_tdata[7:0] == CH_A || m_tdata[7:0] == 8'h00))
        else $error("bad ack byte");

    // A command end closes its burst.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_END) |-> m_tlast)
        else $error("command end not last");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);

`default_nettype wire
